// ===== rtl/eitp_pkg.sv =====
package eitp_pkg;

  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned IpEndW       = 7;
  localparam int unsigned TcpEndW      = 8;
  localparam int unsigned LenW         = 16;

  localparam logic [15:0] EtherTypeIpv6 = 16'h86DD;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'h06;
  localparam logic [3:0]  IpVersion4    = 4'd4;
  localparam logic [3:0]  MinHdrWords   = 4'd5;
  localparam logic [IpEndW-1:0] Ipv6HdrEnd = IpEndW'(54);
  localparam logic [IpEndW-1:0] EthHdrLen  = IpEndW'(14);
  localparam logic [LenW-1:0]   LenMax     = '1;

  typedef enum logic [2:0] {
    PH_ETH     = 3'd0,
    PH_V4      = 3'd1,
    PH_V6      = 3'd2,
    PH_TCP     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_TCP_PAYLOAD  = 3'd0,
    ST_TCP_EMPTY    = 3'd1,
    ST_V6_NH_OTHER  = 3'd2,
    ST_V4_PROTO_OTH = 3'd3,
    ST_ETYPE_OTHER  = 3'd4,
    ST_BAD_VERSION  = 3'd5,
    ST_TRUNCATED    = 3'd6
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } item_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  payload_byte;
    status_e     frame_status;
    logic [7:0]  ip_protocol;
    logic [15:0] ether_kind;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] payload_total;
    logic        run_end;
  } result_t;

endpackage

// ===== rtl/eth_ip_tcp_header_parser.sv =====
// Ethernet / IPv4 / IPv6 / TCP header parser.
// Slave channel: one frame byte per transfer in s_axis_tdata_i, tlast on the
// last captured byte of the frame. Master channel: one result per transfer;
// tuser says payload byte (0) or end-of-frame summary (1), tlast is set on the
// summary. A payload result carries only the byte; the summary carries status,
// protocol, EtherType, TCP ports and payload length.
// An accepted byte passes the input register, then the result register,
// before its result reaches the master side. Throughput: one byte per cycle
// while the receiver takes results; a last byte that is also a payload byte
// yields two results and stays in the input register until the summary is made.
// Header bytes produce no result.
// Reset clears the parse state to the start of an Ethernet header and empties
// both registers. When the receiver stalls, the result register holds its
// transfer and tready drops as soon as the input register holds a byte,
// until the result drains.
module eth_ip_tcp_header_parser #(
  parameter int unsigned COUNT_BITS = eitp_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // frame_byte
  input  logic        s_axis_tlast_i,   // end_of_frame
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // payload_byte, frame_status, ip_protocol,
                                        // ether_kind, source_port,
                                        // destination_port, payload_total, zero pad
  output logic        m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o    // run_end
);
  import eitp_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    out_ready;
  result_t out_res;

  assign in_item.frame_byte   = s_axis_tdata_i;
  assign in_item.end_of_frame = s_axis_tlast_i;

  eitp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .item_o  (held_item),
    .take_i  (take)
  );

  eitp_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (held_valid),
    .item_i       (held_item),
    .out_ready_i  (out_ready),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  eitp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .valid_o     (m_axis_tvalid_o),
    .res_o       (out_res),
    .ready_i     (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {5'd0,
                           out_res.payload_total,
                           out_res.destination_port,
                           out_res.source_port,
                           out_res.ether_kind,
                           out_res.ip_protocol,
                           out_res.frame_status,
                           out_res.payload_byte};
  assign m_axis_tuser_o = out_res.result_kind;
  assign m_axis_tlast_o = out_res.run_end;

endmodule

// ===== rtl/eitp_in_reg.sv =====
module eitp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  eitp_pkg::item_t item_i,
  output logic            valid_o,
  output eitp_pkg::item_t item_o,
  input  logic            take_i
);
  import eitp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ready_o) begin
      valid_d = valid_i;
      item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/eitp_parser.sv =====
module eitp_parser #(
  parameter int unsigned COUNT_BITS = eitp_pkg::CountBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  eitp_pkg::item_t   item_i,
  input  logic              out_ready_i,
  output logic              take_o,
  output logic              res_valid_o,
  output eitp_pkg::result_t res_o
);
  import eitp_pkg::*;

  logic [COUNT_BITS-1:0] pos_q, pos_d, pos_s;
  logic [15:0]           etype_q, etype_d, etype_s;
  logic [IpEndW-1:0]     ip_end_q, ip_end_d, ip_end_s;
  logic [7:0]            proto_q, proto_d, proto_s;
  logic [TcpEndW-1:0]    tcp_end_q, tcp_end_d, tcp_end_s;
  logic [15:0]           sport_q, sport_d, sport_s;
  logic [15:0]           dport_q, dport_d, dport_s;
  logic [LenW-1:0]       cnt_q, cnt_d, cnt_s;
  phase_e                phase_q, phase_d, phase_s;
  logic                  verr_q, verr_d, verr_s;
  logic                  pend_q, pend_d;

  logic                  advance;
  logic                  split_first;
  logic                  emit_sum;
  logic [7:0]            b;
  logic [COUNT_BITS-1:0] p_inc;
  logic [COUNT_BITS-1:0] tcp_off;
  logic [3:0]            hdr_words;
  logic                  opts_reached;
  status_e               status;

  assign b            = item_i.frame_byte;
  assign advance      = item_valid_i && out_ready_i;
  assign split_first  = !pend_q && item_i.end_of_frame && (phase_q == PH_PAYLOAD);
  assign emit_sum     = advance && (pend_q || (item_i.end_of_frame && phase_q != PH_PAYLOAD));
  assign p_inc        = pos_q + COUNT_BITS'(1);
  assign tcp_off      = pos_q - COUNT_BITS'(ip_end_q);
  assign opts_reached = pos_q >= (COUNT_BITS'(ip_end_q) + COUNT_BITS'(12));

  // Header step for one byte; with a summary pending the state already holds it.
  always_comb begin
    pos_s     = pos_q;
    etype_s   = etype_q;
    ip_end_s  = ip_end_q;
    proto_s   = proto_q;
    tcp_end_s = tcp_end_q;
    sport_s   = sport_q;
    dport_s   = dport_q;
    cnt_s     = cnt_q;
    phase_s   = phase_q;
    verr_s    = verr_q;
    hdr_words = MinHdrWords;
    if (!pend_q) begin
      unique case (phase_q)
        PH_ETH: begin
          if (pos_q == COUNT_BITS'(12)) begin
            etype_s = {b, 8'h00};
          end else if (pos_q == COUNT_BITS'(13)) begin
            etype_s = {etype_q[15:8], b};
            if (etype_s == EtherTypeIpv6) begin
              phase_s  = PH_V6;
              ip_end_s = Ipv6HdrEnd;
            end else if (etype_s == EtherTypeIpv4) begin
              phase_s = PH_V4;
            end else begin
              phase_s = PH_SKIP;
            end
          end
        end
        PH_V4: begin
          if (pos_q == COUNT_BITS'(14)) begin
            if (b[7:4] != IpVersion4) begin
              verr_s  = 1'b1;
              phase_s = PH_SKIP;
            end
            hdr_words = (b[3:0] < MinHdrWords) ? MinHdrWords : b[3:0];
            ip_end_s  = EthHdrLen + IpEndW'({hdr_words, 2'b00});
          end else if (pos_q == COUNT_BITS'(23)) begin
            proto_s = b;
            if (b != ProtoTcp) phase_s = PH_SKIP;
          end
          if (phase_s == PH_V4 && pos_q > COUNT_BITS'(23) && p_inc == COUNT_BITS'(ip_end_q)) begin
            phase_s = PH_TCP;
          end
        end
        PH_V6: begin
          if (pos_q == COUNT_BITS'(20)) begin
            proto_s = b;
            if (b != ProtoTcp) phase_s = PH_SKIP;
          end
          if (phase_s == PH_V6 && p_inc == COUNT_BITS'(ip_end_q)) begin
            phase_s = PH_TCP;
          end
        end
        PH_TCP: begin
          if (tcp_off == COUNT_BITS'(0)) begin
            sport_s = {b, 8'h00};
          end else if (tcp_off == COUNT_BITS'(1)) begin
            sport_s = {sport_q[15:8], b};
          end else if (tcp_off == COUNT_BITS'(2)) begin
            dport_s = {b, 8'h00};
          end else if (tcp_off == COUNT_BITS'(3)) begin
            dport_s = {dport_q[15:8], b};
          end else if (tcp_off == COUNT_BITS'(12)) begin
            hdr_words = (b[7:4] < MinHdrWords) ? MinHdrWords : b[7:4];
            tcp_end_s = TcpEndW'(ip_end_q) + TcpEndW'({hdr_words, 2'b00});
          end else if (tcp_off > COUNT_BITS'(12) && p_inc == COUNT_BITS'(tcp_end_q)) begin
            phase_s = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (cnt_q != LenMax) cnt_s = cnt_q + LenW'(1);
        end
        default: begin
        end
      endcase
      if (pos_q != '1) pos_s = p_inc;
    end
  end

  always_comb begin
    if (verr_s) begin
      status = ST_BAD_VERSION;
    end else begin
      case (phase_s)
        PH_SKIP: begin
          if (etype_s == EtherTypeIpv6)      status = ST_V6_NH_OTHER;
          else if (etype_s == EtherTypeIpv4) status = ST_V4_PROTO_OTH;
          else                               status = ST_ETYPE_OTHER;
        end
        PH_TCP:     status = opts_reached ? ST_TCP_EMPTY : ST_TRUNCATED;
        PH_PAYLOAD: status = (cnt_s != '0) ? ST_TCP_PAYLOAD : ST_TCP_EMPTY;
        default:    status = ST_TRUNCATED;
      endcase
    end
  end

  // Next state: commit the step, or clear everything after the summary.
  always_comb begin
    pos_d     = pos_q;
    etype_d   = etype_q;
    ip_end_d  = ip_end_q;
    proto_d   = proto_q;
    tcp_end_d = tcp_end_q;
    sport_d   = sport_q;
    dport_d   = dport_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    verr_d    = verr_q;
    pend_d    = pend_q;
    if (emit_sum) begin
      pos_d     = '0;
      etype_d   = '0;
      ip_end_d  = '0;
      proto_d   = '0;
      tcp_end_d = '0;
      sport_d   = '0;
      dport_d   = '0;
      cnt_d     = '0;
      phase_d   = PH_ETH;
      verr_d    = 1'b0;
      pend_d    = 1'b0;
    end else if (advance) begin
      pos_d     = pos_s;
      etype_d   = etype_s;
      ip_end_d  = ip_end_s;
      proto_d   = proto_s;
      tcp_end_d = tcp_end_s;
      sport_d   = sport_s;
      dport_d   = dport_s;
      cnt_d     = cnt_s;
      phase_d   = phase_s;
      verr_d    = verr_s;
      pend_d    = split_first;
    end
  end

  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    take_o      = advance && !split_first;
    if (emit_sum) begin
      res_valid_o            = 1'b1;
      res_o.result_kind      = KIND_SUMMARY;
      res_o.frame_status     = status;
      res_o.ip_protocol      = proto_s;
      res_o.ether_kind       = etype_s;
      res_o.source_port      = sport_s;
      res_o.destination_port = dport_s;
      res_o.payload_total    = cnt_s;
      res_o.run_end          = 1'b1;
    end else if (advance && phase_q == PH_PAYLOAD) begin
      res_valid_o        = 1'b1;
      res_o.result_kind  = KIND_PAYLOAD;
      res_o.payload_byte = b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      etype_q   <= '0;
      ip_end_q  <= '0;
      proto_q   <= '0;
      tcp_end_q <= '0;
      sport_q   <= '0;
      dport_q   <= '0;
      cnt_q     <= '0;
      phase_q   <= PH_ETH;
      verr_q    <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      etype_q   <= etype_d;
      ip_end_q  <= ip_end_d;
      proto_q   <= proto_d;
      tcp_end_q <= tcp_end_d;
      sport_q   <= sport_d;
      dport_q   <= dport_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      verr_q    <= verr_d;
      pend_q    <= pend_d;
    end
  end

  a_pend_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> item_valid_i)
    else $error("summary pending without its frame byte held");

  a_pend_resolves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && pend_q) |=> !pend_q)
    else $error("pending summary not retired");

  a_payload_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.result_kind == KIND_PAYLOAD) |-> (phase_q == PH_PAYLOAD && !pend_q))
    else $error("payload byte emitted outside payload phase");

  a_summary_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_sum |=> (phase_q == PH_ETH && pos_q == '0 && cnt_q == '0))
    else $error("frame state not cleared after summary");

endmodule

// ===== rtl/eitp_out_reg.sv =====
module eitp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  eitp_pkg::result_t res_i,
  output logic              ready_o,
  output logic              valid_o,
  output eitp_pkg::result_t res_o,
  input  logic              ready_i
);
  import eitp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (ready_o) begin
      valid_d = res_valid_i;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== dv/eth_ip_tcp_header_parser_test.sv =====
module eth_ip_tcp_header_parser_test;

  import eitp_pkg::*;

  localparam int unsigned EtypeHiPos   = 12;
  localparam int unsigned EtypeLoPos   = 13;
  localparam int unsigned V4ProtoPos   = EthHdrLen + 9;
  localparam int unsigned V6NextHdrPos = EthHdrLen + 6;
  localparam int unsigned TcpDoffOff   = 12;
  localparam int unsigned PosMax       = (1 << CountBitsDef) - 1;
  localparam int unsigned StallLimit   = 4000;

  typedef logic [7:0] frame_bytes_t[$];

  typedef enum int {
    FR_V4_TCP,
    FR_V6_TCP,
    FR_V4_OTHER,
    FR_V6_OTHER,
    FR_ETYPE_OTHER,
    FR_BAD_VERSION
  } frame_kind_e;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;

  // per-frame parse state of the predictor
  int unsigned frame_pos;
  logic [15:0] etype_seen;
  int unsigned ip_hdr_end;
  logic [7:0]  ip_proto_seen;
  int unsigned tcp_hdr_end;
  logic [15:0] src_port_seen;
  logic [15:0] dst_port_seen;
  logic [15:0] payload_count;
  phase_e      parse_phase;
  logic        bad_version;

  result_t frame_results_due[$];

  eth_ip_tcp_header_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void clear_frame_state();
    frame_pos     = 0;
    etype_seen    = '0;
    ip_hdr_end    = 0;
    ip_proto_seen = '0;
    tcp_hdr_end   = 0;
    src_port_seen = '0;
    dst_port_seen = '0;
    payload_count = '0;
    parse_phase   = PH_ETH;
    bad_version   = 1'b0;
  endfunction

  function automatic status_e frame_status_for(int unsigned last_pos);
    if (bad_version) return ST_BAD_VERSION;
    case (parse_phase)
      PH_SKIP: begin
        if (etype_seen == EtherTypeIpv6) return ST_V6_NH_OTHER;
        if (etype_seen == EtherTypeIpv4) return ST_V4_PROTO_OTH;
        return ST_ETYPE_OTHER;
      end
      // the data offset byte has been seen once the frame reaches it
      PH_TCP:     return (last_pos >= ip_hdr_end + TcpDoffOff) ? ST_TCP_EMPTY : ST_TRUNCATED;
      PH_PAYLOAD: return (payload_count != 0) ? ST_TCP_PAYLOAD : ST_TCP_EMPTY;
      default:    return ST_TRUNCATED;
    endcase
  endfunction

  task automatic parse_frame_byte(input logic [7:0] b, input logic eof);
    int unsigned p;
    int unsigned words;
    result_t     r;
    p = frame_pos;
    case (parse_phase)
      PH_ETH: begin
        if (p == EtypeHiPos) begin
          etype_seen = {b, 8'h00};
        end else if (p == EtypeLoPos) begin
          etype_seen[7:0] = b;
          if (etype_seen == EtherTypeIpv6) begin
            parse_phase = PH_V6;
            ip_hdr_end  = Ipv6HdrEnd;
          end else if (etype_seen == EtherTypeIpv4) begin
            parse_phase = PH_V4;
          end else begin
            parse_phase = PH_SKIP;
          end
        end
      end
      PH_V4: begin
        if (p == EthHdrLen) begin
          words = b[3:0];
          if (b[7:4] != IpVersion4) begin
            bad_version = 1'b1;
            parse_phase = PH_SKIP;
          end
          if (words < MinHdrWords) words = MinHdrWords;
          ip_hdr_end = EthHdrLen + words * 4;
        end else if (p == V4ProtoPos) begin
          ip_proto_seen = b;
          if (b != ProtoTcp) parse_phase = PH_SKIP;
        end
        if (parse_phase == PH_V4 && p > V4ProtoPos && p + 1 == ip_hdr_end) begin
          parse_phase = PH_TCP;
        end
      end
      PH_V6: begin
        if (p == V6NextHdrPos) begin
          ip_proto_seen = b;
          if (b != ProtoTcp) parse_phase = PH_SKIP;
        end
        if (parse_phase == PH_V6 && p + 1 == ip_hdr_end) parse_phase = PH_TCP;
      end
      PH_TCP: begin
        case (p - ip_hdr_end)
          0: src_port_seen = {b, 8'h00};
          1: src_port_seen[7:0] = b;
          2: dst_port_seen = {b, 8'h00};
          3: dst_port_seen[7:0] = b;
          TcpDoffOff: begin
            words = b[7:4];
            if (words < MinHdrWords) words = MinHdrWords;
            tcp_hdr_end = ip_hdr_end + words * 4;
          end
          default: begin
            if (p - ip_hdr_end > TcpDoffOff && p + 1 == tcp_hdr_end) parse_phase = PH_PAYLOAD;
          end
        endcase
      end
      PH_PAYLOAD: begin
        r = '0;
        r.result_kind  = KIND_PAYLOAD;
        r.payload_byte = b;
        frame_results_due.push_back(r);
        if (payload_count != LenMax) payload_count++;
      end
      default: ;
    endcase

    if (frame_pos < PosMax) frame_pos++;

    if (eof) begin
      r = '0;
      r.result_kind      = KIND_SUMMARY;
      r.frame_status     = frame_status_for(p);
      r.ip_protocol      = ip_proto_seen;
      r.ether_kind       = etype_seen;
      r.source_port      = src_port_seen;
      r.destination_port = dst_port_seen;
      r.payload_total    = payload_count;
      r.run_end          = 1'b1;
      frame_results_due.push_back(r);
      clear_frame_state();
    end
  endtask

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (frame_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tuser %b tlast %b tdata %h",
                 $time, m_tuser, m_tlast, m_tdata);
        mismatch_count++;
      end else begin
        want = frame_results_due.pop_front();
        compare_field("result_kind", want.result_kind, m_tuser);
        compare_field("payload_byte", want.payload_byte, m_tdata[7:0]);
        compare_field("frame_status", want.frame_status, m_tdata[10:8]);
        compare_field("ip_protocol", want.ip_protocol, m_tdata[18:11]);
        compare_field("ether_kind", want.ether_kind, m_tdata[34:19]);
        compare_field("source_port", want.source_port, m_tdata[50:35]);
        compare_field("destination_port", want.destination_port, m_tdata[66:51]);
        compare_field("payload_total", want.payload_total, m_tdata[82:67]);
        compare_field("run_end", want.run_end, m_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("eth_ip_tcp_header_parser_test failed");
    $finish;
  end

  function automatic void build_frame(input frame_kind_e kind, input int unsigned ihl,
                                      input int unsigned doff, input int unsigned pay_len,
                                      output frame_bytes_t f);
    int unsigned hdr_len;
    int unsigned base;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  version;
    f = {};
    repeat (EtypeHiPos) f.push_back(8'($urandom));
    case (kind)
      FR_V4_TCP, FR_V4_OTHER, FR_BAD_VERSION: etype = EtherTypeIpv4;
      FR_V6_TCP, FR_V6_OTHER:                 etype = EtherTypeIpv6;
      default: begin
        do etype = 16'($urandom); while (etype == EtherTypeIpv4 || etype == EtherTypeIpv6);
      end
    endcase
    f.push_back(etype[15:8]);
    f.push_back(etype[7:0]);
    do proto = 8'($urandom); while (proto == ProtoTcp);
    if (kind == FR_V4_TCP || kind == FR_V6_TCP) proto = ProtoTcp;

    if (etype == EtherTypeIpv4) begin
      hdr_len = ((ihl < MinHdrWords) ? MinHdrWords : ihl) * 4;
      repeat (hdr_len) f.push_back(8'($urandom));
      version = IpVersion4;
      if (kind == FR_BAD_VERSION) begin
        do version = 4'($urandom); while (version == IpVersion4);
      end
      f[EthHdrLen]  = {version, 4'(ihl)};
      f[V4ProtoPos] = proto;
    end else if (etype == EtherTypeIpv6) begin
      repeat (Ipv6HdrEnd - EthHdrLen) f.push_back(8'($urandom));
      f[V6NextHdrPos] = proto;
    end

    if (kind == FR_V4_TCP || kind == FR_V6_TCP) begin
      base    = f.size();
      hdr_len = ((doff < MinHdrWords) ? MinHdrWords : doff) * 4;
      repeat (hdr_len) f.push_back(8'($urandom));
      f[base + TcpDoffOff] = {4'(doff), 4'($urandom)};
      repeat (pay_len) f.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(30)) f.push_back(8'($urandom));
    end
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic eof, input bit no_gaps);
    @(negedge clk_i);
    if (!no_gaps) begin
      while ($urandom_range(99) < src_idle_pct) begin
        s_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= eof;
    do @(posedge clk_i); while (!s_tready);
    parse_frame_byte(value, eof);
  endtask

  task automatic send_frame(input frame_bytes_t f, input bit no_gaps);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1, no_gaps);
  endtask

  // hold the input side until every predicted result has drained
  task automatic wait_for_drain();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_header_corner_cases();
    frame_bytes_t f;
    src_idle_pct   = 30;
    sink_stall_pct = 30;

    // frames cut before, inside and right after the EtherType
    build_frame(FR_V4_TCP, 5, 5, 3, f);
    send_frame(f[0:0], 1'b0);
    send_frame(f[0:EtypeHiPos], 1'b0);
    send_frame(f[0:EtypeLoPos], 1'b0);

    build_frame(FR_ETYPE_OTHER, 5, 5, 0, f);
    f[EtypeHiPos] = 8'hFF;
    f[EtypeLoPos] = 8'hFF;
    send_frame(f, 1'b0);
    f[EtypeHiPos] = 8'h08;
    f[EtypeLoPos] = 8'h01;
    send_frame(f, 1'b0);

    build_frame(FR_BAD_VERSION, 5, 5, 0, f);
    f[EthHdrLen] = 8'hF5;
    send_frame(f, 1'b0);
    f[EthHdrLen] = 8'h05;
    send_frame(f, 1'b0);

    // IHL and data offset below the minimum, extreme ports and payload bytes
    build_frame(FR_V4_TCP, 0, 0, 4, f);
    f[34] = 8'hFF;
    f[35] = 8'hFF;
    f[36] = 8'h00;
    f[37] = 8'h00;
    f[f.size() - 2] = 8'h00;
    f[f.size() - 1] = 8'hFF;
    send_frame(f, 1'b0);

    build_frame(FR_V4_OTHER, 5, 5, 0, f);
    f[V4ProtoPos] = 8'hFF;
    send_frame(f, 1'b0);
    f[V4ProtoPos] = 8'h00;
    send_frame(f, 1'b0);

    build_frame(FR_V6_OTHER, 5, 5, 0, f);
    send_frame(f, 1'b0);

    // ends exactly at the end of a full-size TCP header
    build_frame(FR_V6_TCP, 5, 15, 0, f);
    send_frame(f, 1'b0);

    // ends inside the IPv4 options
    build_frame(FR_V4_TCP, 15, 5, 2, f);
    send_frame(f[0:40], 1'b0);

    // ends on the protocol byte, just before and on the data offset byte
    build_frame(FR_V4_TCP, 5, 5, 5, f);
    send_frame(f[0:V4ProtoPos], 1'b0);
    send_frame(f[0:34 + TcpDoffOff - 1], 1'b0);
    send_frame(f[0:34 + TcpDoffOff], 1'b0);

    // ends inside the TCP options
    build_frame(FR_V4_TCP, 5, 15, 4, f);
    send_frame(f[0:34 + 30], 1'b0);

    // last byte is a payload byte: two results from one transfer
    build_frame(FR_V4_TCP, 7, 6, 1, f);
    send_frame(f, 1'b0);

    build_frame(FR_V6_TCP, 5, 5, 10, f);
    send_frame(f[0:f.size() - 4], 1'b0);
    wait_for_drain();
  endtask

  task automatic test_long_payload_run();
    frame_bytes_t f;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // a long run of payload bytes with no gaps
    build_frame(FR_V4_TCP, 5, 5, 60, f);
    send_frame(f, 1'b1);
    wait_for_drain();
  endtask

  function automatic void random_frame(output frame_bytes_t f);
    frame_kind_e kind;
    int unsigned pick;
    int unsigned ihl;
    int unsigned doff;
    int unsigned pay_len;
    pick = $urandom_range(99);
    if (pick < 45)      kind = FR_V4_TCP;
    else if (pick < 70) kind = FR_V6_TCP;
    else if (pick < 78) kind = FR_V4_OTHER;
    else if (pick < 85) kind = FR_V6_OTHER;
    else if (pick < 92) kind = FR_ETYPE_OTHER;
    else                kind = FR_BAD_VERSION;
    ihl     = ($urandom_range(3) != 0) ? 5 : $urandom_range(15);
    doff    = ($urandom_range(3) != 0) ? $urandom_range(8, 5) : $urandom_range(15);
    pay_len = ($urandom_range(4) == 0) ? 0 : $urandom_range(16);
    build_frame(kind, ihl, doff, pay_len, f);
    if ($urandom_range(3) == 0) f = f[0:$urandom_range(f.size() - 1)];
  endfunction

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned byte_budget);
    frame_bytes_t f;
    int unsigned  sent;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < byte_budget) begin
      random_frame(f);
      if ($urandom_range(7) == 0) wait_for_drain();
      // some frames go out back to back
      send_frame(f, $urandom_range(3) == 0);
      sent += f.size();
    end
    wait_for_drain();
  endtask

  initial begin
    clear_frame_state();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_header_corner_cases();
    test_long_payload_run();
    test_random_traffic(0, 0, 90);
    test_random_traffic(83, 0, 90);
    test_random_traffic(0, 83, 90);
    test_random_traffic(9, 9, 90);

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && frame_results_due.size() == 0) begin
      $display("eth_ip_tcp_header_parser_test passed");
    end else begin
      $display("eth_ip_tcp_header_parser_test failed");
    end
    $finish;
  end

endmodule
